// ===== sv/pru_pkg.sv =====
package pru_pkg;

  localparam int DEF_MAX_WIDTH  = 4096;
  localparam int DEF_MAX_FACTOR = 100;

  localparam int PIXEL_W    = 24;
  localparam int FACTOR_W   = 7;
  localparam int SWIDTH_W   = 13;
  localparam int HEIGHT_W   = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_FACTOR  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_HEIGHT = 2'd2;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_PULL = 1'b1;

  localparam logic [1:0] ST_PIXEL   = 2'd0;
  localparam logic [1:0] ST_LOADED  = 2'd1;
  localparam logic [1:0] ST_NO_ROW  = 2'd2;
  localparam logic [1:0] ST_REFUSED = 2'd3;

  typedef struct packed {
    logic       opcode;
    logic [7:0] in_blue;
    logic [7:0] in_green;
    logic [7:0] in_red;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] out_blue;
    logic [7:0] out_green;
    logic [7:0] out_red;
    logic [1:0] pad_bytes;
    logic       row_end;
    logic       image_end;
  } out_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [1:0] pad_bytes;
    logic       row_end;
    logic       image_end;
  } pru_meta_t;

endpackage

// ===== sv/pixel_replication_upscaler_top.sv =====
// Nearest-neighbour integer upscaler for 24-bit pixels. Load transfers fill a single-port
// line buffer of MAX_WIDTH pixels; once a full source row is held, pull transfers return
// the enlarged row, each pixel repeated scale_factor times and the row replayed
// scale_factor times. One transfer is taken every clock, loads and pulls alike, unless a
// stalled result holds it back; its result is offered in the next cycle, from the registered
// read of the line buffer. A new transfer is taken while a result waits, unless the result
// is stalled. The line buffer needs no clearing after reset, so the block is ready at once.
module pixel_replication_upscaler_top
  import pru_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_FACTOR = DEF_MAX_FACTOR
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  logic               accept;
  logic               ram_en;
  logic               ram_we;
  logic [AW-1:0]      ram_addr;
  logic [PIXEL_W-1:0] ram_wdata;
  logic [PIXEL_W-1:0] ram_rdata;
  pru_meta_t          meta;
  pru_meta_t          meta_r, meta_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               pixel_given;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  pru_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_FACTOR (MAX_FACTOR)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .item      (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .ram_en    (ram_en),
    .ram_we    (ram_we),
    .ram_addr  (ram_addr),
    .ram_wdata (ram_wdata),
    .meta      (meta)
  );

  pru_ram #(
    .WIDTH (PIXEL_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    meta_nxt      = meta_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
      meta_nxt      = meta;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    meta_r <= meta_nxt;
  end

  assign pixel_given        = meta_r.status == ST_PIXEL;
  assign out_valid          = out_valid_r;
  assign out_data.status    = meta_r.status;
  assign out_data.out_blue  = pixel_given ? ram_rdata[7:0]   : 8'd0;
  assign out_data.out_green = pixel_given ? ram_rdata[15:8]  : 8'd0;
  assign out_data.out_red   = pixel_given ? ram_rdata[23:16] : 8'd0;
  assign out_data.pad_bytes = meta_r.pad_bytes;
  assign out_data.row_end   = meta_r.row_end;
  assign out_data.image_end = meta_r.image_end;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> out_valid_r && $stable(meta_r))
    else $error("stalled result was replaced");

  a_flags_only_on_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && meta_r.status != ST_PIXEL |-> !meta_r.row_end && !meta_r.image_end)
    else $error("row or image end flagged on a non-pixel result");

  a_image_end_is_row_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && meta_r.image_end |-> meta_r.row_end)
    else $error("image end without row end");

endmodule

// ===== sv/pru_ram.sv =====
module pru_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 4096,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             en,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

// ===== sv/pru_ctrl.sv =====
module pru_ctrl
  import pru_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_FACTOR = DEF_MAX_FACTOR,
  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  accept,
  input  in_item_t              item,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  ram_en,
  output logic                  ram_we,
  output logic [AW-1:0]         ram_addr,
  output logic [PIXEL_W-1:0]    ram_wdata,
  output pru_meta_t             meta
);

  localparam int LW   = $clog2(MAX_WIDTH + 1);
  localparam int WCW  = (LW > SWIDTH_W) ? LW : SWIDTH_W;
  localparam int FW   = $clog2(MAX_FACTOR + 1);
  localparam int FCW  = (FW > FACTOR_W) ? FW : FACTOR_W;
  localparam int HCW  = HEIGHT_W + 1;

  logic [FACTOR_W-1:0] scale_factor_r, scale_factor_nxt;
  logic [SWIDTH_W-1:0] source_width_r, source_width_nxt;
  logic [HEIGHT_W-1:0] source_height_r, source_height_nxt;

  logic [LW-1:0]       loaded_count_r, loaded_count_nxt;
  logic [AW-1:0]       read_column_r, read_column_nxt;
  logic [FW-1:0]       across_repeat_r, across_repeat_nxt;
  logic [FW-1:0]       down_repeat_r, down_repeat_nxt;
  logic                row_ready_r, row_ready_nxt;
  logic [HEIGHT_W-1:0] rows_finished_r, rows_finished_nxt;

  logic [FCW-1:0] f_eff;
  logic [WCW-1:0] w_eff;
  logic [HEIGHT_W-1:0] h_eff;
  logic [WCW-1:0] lc_inc;
  logic [WCW-1:0] rc_inc;
  logic [FCW-1:0] across_inc;
  logic [FCW-1:0] down_inc;
  logic [HCW-1:0] rows_inc;
  logic [3:0]     pad_prod;

  always_comb begin
    if (scale_factor_r == '0) begin
      f_eff = FCW'(1);
    end else if (FCW'(scale_factor_r) > FCW'(MAX_FACTOR)) begin
      f_eff = FCW'(MAX_FACTOR);
    end else begin
      f_eff = FCW'(scale_factor_r);
    end
    if (source_width_r == '0) begin
      w_eff = WCW'(1);
    end else if (WCW'(source_width_r) > WCW'(MAX_WIDTH)) begin
      w_eff = WCW'(MAX_WIDTH);
    end else begin
      w_eff = WCW'(source_width_r);
    end
    h_eff = (source_height_r == '0) ? HEIGHT_W'(1) : source_height_r;
  end

  assign lc_inc     = WCW'(loaded_count_r) + WCW'(1);
  assign rc_inc     = WCW'(read_column_r) + WCW'(1);
  assign across_inc = FCW'(across_repeat_r) + FCW'(1);
  assign down_inc   = FCW'(down_repeat_r) + FCW'(1);
  assign rows_inc   = HCW'(rows_finished_r) + HCW'(1);
  assign pad_prod   = {2'b00, w_eff[1:0]} * {2'b00, f_eff[1:0]};

  always_comb begin
    scale_factor_nxt  = scale_factor_r;
    source_width_nxt  = source_width_r;
    source_height_nxt = source_height_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_SCALE_FACTOR:  scale_factor_nxt  = cfg_data[FACTOR_W-1:0];
        CFG_SOURCE_WIDTH:  source_width_nxt  = cfg_data[SWIDTH_W-1:0];
        CFG_SOURCE_HEIGHT: source_height_nxt = cfg_data[HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    loaded_count_nxt  = loaded_count_r;
    read_column_nxt   = read_column_r;
    across_repeat_nxt = across_repeat_r;
    down_repeat_nxt   = down_repeat_r;
    row_ready_nxt     = row_ready_r;
    rows_finished_nxt = rows_finished_r;
    ram_en    = 1'b0;
    ram_we    = 1'b0;
    ram_addr  = read_column_r;
    ram_wdata = {item.in_red, item.in_green, item.in_blue};
    meta      = '0;

    if (item.opcode == OP_LOAD) begin
      ram_addr = loaded_count_r[AW-1:0];
      if (row_ready_r) begin
        meta.status = ST_REFUSED;
      end else begin
        meta.status = ST_LOADED;
        if (accept) begin
          ram_en = WCW'(loaded_count_r) < WCW'(MAX_WIDTH);
          ram_we = ram_en;
          loaded_count_nxt = LW'(lc_inc);
          if (lc_inc >= w_eff) begin
            row_ready_nxt     = 1'b1;
            read_column_nxt   = '0;
            across_repeat_nxt = '0;
            down_repeat_nxt   = '0;
          end
        end
      end
    end else if (!row_ready_r) begin
      meta.status = ST_NO_ROW;
    end else begin
      meta.status = ST_PIXEL;
      ram_en      = accept;
      across_repeat_nxt = FW'(across_inc);
      if (across_inc >= f_eff) begin
        across_repeat_nxt = '0;
        read_column_nxt   = AW'(rc_inc);
        if (rc_inc >= w_eff) begin
          meta.row_end    = 1'b1;
          meta.pad_bytes  = pad_prod[1:0];
          read_column_nxt = '0;
          down_repeat_nxt = FW'(down_inc);
          if (down_inc >= f_eff) begin
            down_repeat_nxt   = '0;
            row_ready_nxt     = 1'b0;
            loaded_count_nxt  = '0;
            rows_finished_nxt = HEIGHT_W'(rows_inc);
            if (rows_inc >= HCW'(h_eff)) begin
              rows_finished_nxt = '0;
              meta.image_end    = 1'b1;
            end
          end
        end
      end
      if (!accept) begin
        across_repeat_nxt = across_repeat_r;
        read_column_nxt   = read_column_r;
        down_repeat_nxt   = down_repeat_r;
        row_ready_nxt     = row_ready_r;
        loaded_count_nxt  = loaded_count_r;
        rows_finished_nxt = rows_finished_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_factor_r  <= FACTOR_W'(1);
      source_width_r  <= SWIDTH_W'(1);
      source_height_r <= HEIGHT_W'(1);
      loaded_count_r  <= '0;
      read_column_r   <= '0;
      across_repeat_r <= '0;
      down_repeat_r   <= '0;
      row_ready_r     <= 1'b0;
      rows_finished_r <= '0;
    end else begin
      scale_factor_r  <= scale_factor_nxt;
      source_width_r  <= source_width_nxt;
      source_height_r <= source_height_nxt;
      loaded_count_r  <= loaded_count_nxt;
      read_column_r   <= read_column_nxt;
      across_repeat_r <= across_repeat_nxt;
      down_repeat_r   <= down_repeat_nxt;
      row_ready_r     <= row_ready_nxt;
      rows_finished_r <= rows_finished_nxt;
    end
  end

  a_write_only_while_filling: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> !row_ready_r)
    else $error("line buffer written while a row is being replayed");

  a_ready_rises_on_load: assert property (@(posedge clk) disable iff (!rst_n)
    !row_ready_r ##1 row_ready_r |-> $past(accept) && $past(item.opcode) == OP_LOAD)
    else $error("row became ready without a load transfer");

  a_row_done_clears_count: assert property (@(posedge clk) disable iff (!rst_n)
    row_ready_r ##1 !row_ready_r |-> loaded_count_r == '0 && down_repeat_r == '0)
    else $error("row finished without clearing the fill count");

  a_image_end_wraps: assert property (@(posedge clk) disable iff (!rst_n)
    accept && meta.image_end |=> rows_finished_r == '0 && !row_ready_r)
    else $error("image end did not return the row counter to zero");

endmodule

// ===== tb/sv/upscale_checker.sv =====
`timescale 1ns / 100ps

module upscale_checker
  import pru_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  in_item_t              in_data,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int unsigned           results_owed,
  output int unsigned           failures
);

  localparam int unsigned ROW_ALIGN   = 4;
  localparam int unsigned PIXEL_BYTES = 3;

  logic [FACTOR_W-1:0] factor;
  logic [SWIDTH_W-1:0] src_width;
  logic [HEIGHT_W-1:0] src_height;

  logic [PIXEL_W-1:0] row_pixels [DEF_MAX_WIDTH];
  int unsigned fill_count;
  int unsigned column;
  int unsigned across;
  int unsigned down;
  int unsigned rows_done;
  bit          row_held;

  out_item_t   owed_pixels [$];
  out_item_t   oldest;
  int unsigned fault_count = 0;

  assign failures = fault_count;

  function automatic int unsigned clamp_reg(int unsigned raw, int unsigned ceiling);
    if (raw == 0) begin
      return 1;
    end
    return (raw > ceiling) ? ceiling : raw;
  endfunction

  // Advances the upscaler state by one transfer and returns the result it should produce.
  function automatic out_item_t upscale_step(in_item_t item);
    int unsigned reps;
    int unsigned cols;
    int unsigned rows;
    out_item_t   res;
    reps = clamp_reg(factor, DEF_MAX_FACTOR);
    cols = clamp_reg(src_width, DEF_MAX_WIDTH);
    rows = clamp_reg(src_height, 2 ** HEIGHT_W - 1);
    res  = '0;
    if (item.opcode == OP_LOAD) begin
      if (row_held) begin
        res.status = ST_REFUSED;
        return res;
      end
      if (fill_count < DEF_MAX_WIDTH) begin
        row_pixels[fill_count] = {item.in_red, item.in_green, item.in_blue};
      end
      fill_count++;
      if (fill_count >= cols) begin
        row_held = 1'b1;
        column   = 0;
        across   = 0;
        down     = 0;
      end
      res.status = ST_LOADED;
      return res;
    end
    if (!row_held) begin
      res.status = ST_NO_ROW;
      return res;
    end
    {res.out_red, res.out_green, res.out_blue} = row_pixels[column % DEF_MAX_WIDTH];
    across++;
    if (across >= reps) begin
      across = 0;
      column++;
      if (column >= cols) begin
        res.pad_bytes = 2'((ROW_ALIGN - ((cols % ROW_ALIGN) * (reps % ROW_ALIGN)
                                         * PIXEL_BYTES) % ROW_ALIGN) % ROW_ALIGN);
        res.row_end = 1'b1;
        column = 0;
        down++;
        if (down >= reps) begin
          down       = 0;
          row_held   = 1'b0;
          fill_count = 0;
          rows_done++;
          if (rows_done >= rows) begin
            rows_done     = 0;
            res.image_end = 1'b1;
          end
        end
      end
    end
    res.status = ST_PIXEL;
    return res;
  endfunction

  function automatic void compare_field(string field, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      fault_count++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      factor     = FACTOR_W'(1);
      src_width  = SWIDTH_W'(1);
      src_height = HEIGHT_W'(1);
      fill_count = 0;
      column     = 0;
      across     = 0;
      down       = 0;
      rows_done  = 0;
      row_held   = 1'b0;
      owed_pixels.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_SCALE_FACTOR: begin
            factor = cfg_data[FACTOR_W-1:0];
          end
          CFG_SOURCE_WIDTH: begin
            src_width = cfg_data[SWIDTH_W-1:0];
          end
          CFG_SOURCE_HEIGHT: begin
            src_height = cfg_data[HEIGHT_W-1:0];
          end
          default: begin
          end
        endcase
      end
      if (out_valid && out_ready) begin
        if (owed_pixels.size() == 0) begin
          fault_count++;
          $display("%0t: unexpected result, expected none, got %h", $time, out_data);
        end else begin
          oldest = owed_pixels.pop_front();
          compare_field("status", 8'(oldest.status), 8'(out_data.status));
          compare_field("out_blue", oldest.out_blue, out_data.out_blue);
          compare_field("out_green", oldest.out_green, out_data.out_green);
          compare_field("out_red", oldest.out_red, out_data.out_red);
          compare_field("pad_bytes", 8'(oldest.pad_bytes), 8'(out_data.pad_bytes));
          compare_field("row_end", 8'(oldest.row_end), 8'(out_data.row_end));
          compare_field("image_end", 8'(oldest.image_end), 8'(out_data.image_end));
        end
      end
      if (in_valid && in_ready) begin
        owed_pixels.push_back(upscale_step(in_data));
      end
    end
    results_owed <= owed_pixels.size();
  end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import pru_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int unsigned RANDOM_ITEMS = 900;
  localparam int unsigned CALM_ITEMS   = 780;
  localparam int unsigned IDLE_LIMIT   = 1000;
  localparam int unsigned TAIL_CYCLES  = 20;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b1;
  out_item_t             out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int unsigned           results_owed;
  int unsigned           failures;

  logic [FACTOR_W-1:0] cur_factor = 1;
  logic [SWIDTH_W-1:0] cur_width = 1;
  logic [HEIGHT_W-1:0] cur_height = 1;
  int unsigned         sent_count = 0;
  int unsigned         gap_pct = 20;
  bit                  calm = 1'b0;

  int unsigned stall_left = 0;
  int unsigned stretch_left = 0;
  int unsigned stall_pct = 0;
  int unsigned quiet_cycles = 0;

  pixel_replication_upscaler_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  upscale_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .results_owed (results_owed),
    .failures     (failures)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready    <= 1'b1;
      stall_left   <= 0;
      stretch_left <= 0;
    end else begin
      if (stretch_left == 0) begin
        stretch_left <= $urandom_range(16, 256);
        case ($urandom_range(0, 2))
          0: stall_pct <= 0;
          1: stall_pct <= 10;
          default: stall_pct <= 35;
        endcase
      end else begin
        stretch_left <= stretch_left - 1;
      end
      if (stall_left != 0) begin
        out_ready  <= 1'b0;
        stall_left <= stall_left - 1;
      end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
        out_ready  <= 1'b0;
        stall_left <= $urandom_range(0, 8);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("pixel_replication_upscaler_top regression: fail");
      $finish;
    end
  end

  function automatic int unsigned clamp_cfg(int unsigned raw, int unsigned ceiling);
    if (raw == 0) begin
      return 1;
    end
    return (raw > ceiling) ? ceiling : raw;
  endfunction

  task automatic send(input logic op, input logic [PIXEL_W-1:0] px);
    in_item_t item;
    item.opcode   = op;
    item.in_blue  = px[7:0];
    item.in_green = px[15:8];
    item.in_red   = px[23:16];
    if (!calm && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    sent_count++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
  endtask

  // Unused upper bits of each register carry random data, which must be ignored.
  task automatic set_regs(input logic [FACTOR_W-1:0] f, input logic [SWIDTH_W-1:0] w,
                          input logic [HEIGHT_W-1:0] h);
    write_reg(CFG_SCALE_FACTOR, {(CFG_DATA_W - FACTOR_W)'($urandom), f});
    write_reg(CFG_SOURCE_WIDTH, {(CFG_DATA_W - SWIDTH_W)'($urandom), w});
    write_reg(CFG_SOURCE_HEIGHT, h);
    cfg_we     <= 1'b0;
    cur_factor = f;
    cur_width  = w;
    cur_height = h;
  endtask

  // A whole image: each row is loaded and then read out completely, with stray pulls
  // before a row is complete and stray loads while it is held.
  task automatic run_image(input int unsigned noise_pct);
    int unsigned reps;
    int unsigned cols;
    int unsigned rows;
    int unsigned r;
    int unsigned c;
    int unsigned p;
    reps = clamp_cfg(cur_factor, DEF_MAX_FACTOR);
    cols = clamp_cfg(cur_width, DEF_MAX_WIDTH);
    rows = clamp_cfg(cur_height, 2 ** HEIGHT_W - 1);
    for (r = 0; r < rows; r++) begin
      for (c = 0; c < cols; c++) begin
        if ($urandom_range(0, 99) < noise_pct) begin
          send(OP_PULL, $urandom());
        end
        send(OP_LOAD, $urandom());
      end
      for (p = 0; p < cols * reps * reps; p++) begin
        if ($urandom_range(0, 99) < noise_pct) begin
          send(OP_LOAD, $urandom());
        end
        send(OP_PULL, $urandom());
      end
    end
  endtask

  initial begin : stimulus
    int unsigned         base;
    logic [FACTOR_W-1:0] f;
    logic [SWIDTH_W-1:0] w;
    logic [HEIGHT_W-1:0] h;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    send(OP_PULL, 24'hFFFFFF);
    send(OP_LOAD, 24'hFFFFFF);
    send(OP_LOAD, 24'h000000);
    send(OP_PULL, 24'h000000);
    drain();
    write_reg(CFG_UNUSED, 16'hFFFF);
    cfg_we <= 1'b0;

    // The factor shrinks part way through a row.
    set_regs(3, 2, 1);
    send(OP_LOAD, 24'h00FF00);
    send(OP_LOAD, 24'hFF00FF);
    repeat (4) send(OP_PULL, $urandom());
    drain();
    set_regs(1, 2, 1);
    send(OP_PULL, $urandom());
    drain();

    // The width shrinks while a row is held, then grows back over entries already written.
    set_regs(1, 4, 1);
    repeat (4) send(OP_LOAD, $urandom());
    send(OP_PULL, $urandom());
    drain();
    set_regs(1, 2, 1);
    send(OP_PULL, $urandom());
    repeat (2) send(OP_LOAD, $urandom());
    send(OP_PULL, $urandom());
    drain();
    set_regs(1, 4, 1);
    repeat (3) send(OP_PULL, $urandom());
    drain();

    // The tallest image is cut short once rows already exceed the new height.
    set_regs(1, 1, 16'hFFFF);
    repeat (2) begin
      send(OP_LOAD, $urandom());
      send(OP_PULL, $urandom());
    end
    drain();
    set_regs(1, 1, 1);
    send(OP_LOAD, $urandom());
    send(OP_PULL, $urandom());
    drain();

    // An oversized factor saturates, so the first output row ends after the largest
    // repeat count; the factor then drops to finish the image.
    set_regs(7'($urandom_range(DEF_MAX_FACTOR, 127)), 1, 0);
    send(OP_LOAD, $urandom());
    repeat (DEF_MAX_FACTOR) send(OP_PULL, $urandom());
    drain();
    set_regs(1, 1, 1);
    send(OP_PULL, $urandom());
    drain();

    base = sent_count;
    while (sent_count - base < RANDOM_ITEMS) begin
      if (sent_count - base >= CALM_ITEMS) begin
        calm = 1'b1;
      end
      f = $urandom_range(0, 4);
      w = $urandom_range(1, 8);
      case ($urandom_range(0, 9))
        0: w = 0;
        1: w = $urandom_range(9, 40);
        2: begin
          f = $urandom_range(5, 7);
          w = $urandom_range(1, 3);
        end
        default: begin
        end
      endcase
      if (w > 8 && f > 2) begin
        f = 2;
      end
      h = $urandom_range(0, 3);
      case ($urandom_range(0, 2))
        0: gap_pct = 0;
        1: gap_pct = 10;
        default: gap_pct = 40;
      endcase
      set_regs(f, w, h);
      run_image($urandom_range(0, 25));
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (failures == 0 && results_owed == 0) begin
      $display("pixel_replication_upscaler_top regression: pass");
    end else begin
      $display("pixel_replication_upscaler_top regression: fail");
    end
    $finish;
  end

endmodule
